// ===== rtl/qsu_pkg.sv =====
// package for the quoted string unescaper: beat types, phase codes, result kinds
// and the per-byte decode functions; no dependencies
`default_nettype none

package qsu_pkg;

  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);
  localparam int unsigned IdxW   = $clog2(MaxRes);

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_QUOTE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [7:0] QUOTE_RESET = 8'd34;
  localparam logic [7:0] CH_BSLASH   = 8'h5c;
  localparam logic [7:0] CH_X        = 8'h78;
  localparam logic [7:0] CH_N        = 8'h6e;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_R        = 8'h72;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_LA       = 8'h61;
  localparam logic [7:0] CH_LF       = 8'h66;
  localparam logic [7:0] CH_UA       = 8'h41;
  localparam logic [7:0] CH_UF       = 8'h46;
  localparam logic [7:0] BYTE_LF     = 8'd10;
  localparam logic [7:0] BYTE_TAB    = 8'd9;
  localparam logic [7:0] BYTE_CR     = 8'd13;
  localparam logic [7:0] BYTE_NUL    = 8'd0;
  localparam logic [3:0] HEX_TEN     = 4'd10;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_TEXT  = 3'd1,
    PH_ESC   = 3'd2,
    PH_X0    = 3'd3,
    PH_X1    = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       run_last;
  } out_beat_t;

  typedef struct packed {
    out_beat_t [MaxRes-1:0] r;
    logic [CntW-1:0]        n;
  } group_t;

  typedef struct packed {
    group_t     g;
    phase_t     ph;
    logic [7:0] held;
  } dec_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LF) ||
           (c >= CH_UA && c <= CH_UF);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) v = c - CH_ZERO;
    else if (c >= CH_LA && c <= CH_LF) v = c - CH_LA + {4'd0, HEX_TEN};
    else if (c >= CH_UA && c <= CH_UF) v = c - CH_UA + {4'd0, HEX_TEN};
    return v[3:0];
  endfunction

  function automatic dec_t push(input dec_t d, input logic [7:0] b, input logic [1:0] k);
    dec_t o;
    o = d;
    if (d.g.n < CntW'(MaxRes)) begin
      o.g.r[d.g.n[IdxW-1:0]].out_byte = (k == KIND_DATA) ? b : 8'd0;
      o.g.r[d.g.n[IdxW-1:0]].kind     = k;
      o.g.r[d.g.n[IdxW-1:0]].run_last = 1'b0;
      o.g.n = d.g.n + CntW'(1);
    end
    return o;
  endfunction

  // one byte in the start or text phase
  function automatic dec_t feed_plain(input dec_t d, input logic [7:0] b,
                                      input logic [7:0] quote);
    dec_t o;
    o = d;
    if (d.ph == PH_START) begin
      o.ph = PH_TEXT;
      if (b == quote) return o;
    end
    if (b == CH_BSLASH) begin
      o.ph = PH_ESC;
    end else if (b == quote) begin
      o = push(o, 8'd0, KIND_QUOTE);
      o.ph = PH_START;
    end else begin
      o = push(o, b, KIND_DATA);
    end
    return o;
  endfunction

  function automatic dec_t decode(input phase_t ph, input logic [7:0] held,
                                  input logic [7:0] b, input logic last,
                                  input logic [7:0] quote);
    dec_t d;
    logic [7:0] v;
    d = '0;
    d.ph = ph;
    d.held = held;
    v = b;
    case (ph)
      PH_TEXT: d = feed_plain(d, b, quote);
      PH_ESC: begin
        if (b == BYTE_NUL) begin
          d = push(d, 8'd0, KIND_END);
          d.ph = PH_START;
        end else if (b == CH_X) begin
          if (last) begin
            d = push(d, CH_X, KIND_DATA);
            d.ph = PH_TEXT;
          end else begin
            d.ph = PH_X0;
          end
        end else begin
          if (b == CH_N) v = BYTE_LF;
          else if (b == CH_T) v = BYTE_TAB;
          else if (b == CH_R) v = BYTE_CR;
          else if (b == CH_ZERO) v = BYTE_NUL;
          d = push(d, v, KIND_DATA);
          d.ph = PH_TEXT;
        end
      end
      PH_X0: begin
        if (is_hex(b) && !last) begin
          d.held = b;
          d.ph = PH_X1;
        end else begin
          d = push(d, CH_X, KIND_DATA);
          d.ph = PH_TEXT;
          d = feed_plain(d, b, quote);
        end
      end
      PH_X1: begin
        if (is_hex(b)) begin
          d = push(d, {hex_val(held), hex_val(b)}, KIND_DATA);
          d.ph = PH_TEXT;
        end else begin
          d = push(d, CH_X, KIND_DATA);
          d.ph = PH_TEXT;
          d = feed_plain(d, held, quote);
          d = feed_plain(d, b, quote);
        end
      end
      default: begin
        d.ph = PH_START;
        d = feed_plain(d, b, quote);
      end
    endcase
    if (last && d.ph != PH_START) begin
      d = push(d, 8'd0, KIND_END);
      d.ph = PH_START;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/quoted_string_unescaper.sv =====
// top level of the quoted string unescaper: quote register, decoder, serializer
// depends on qsu_pkg, qsu_decode, qsu_serializer
//
// Each accepted input beat is decoded in the cycle it is taken and its results
// (zero to four) are held in a result group register, then presented one result
// beat per cycle while out_stall is low. A byte can be taken every cycle as long
// as each byte gives at most one result and the output is not stalled; a byte
// that gives several results holds the input until the single output port
// drains the group. Input is taken in the same cycle as the final result of the
// previous group. The quote byte is set by cfg_wr_en/cfg_wr_data, resets to 34.
`default_nettype none

module quoted_string_unescaper
  import qsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_beat_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_beat_t       out_data
);

  logic [7:0] quote_byte;
  logic       can_load;
  logic       accept;
  logic       load;
  group_t     grp;

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_byte <= QUOTE_RESET;
    end else if (cfg_wr_en) begin
      quote_byte <= cfg_wr_data;
    end
  end

  assign in_stall = !can_load;
  assign accept   = in_valid && can_load;
  assign load     = accept && (grp.n != '0);

  qsu_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .beat   (in_data),
    .quote  (quote_byte),
    .grp    (grp)
  );

  qsu_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .grp_in    (grp),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/qsu_decode.sv =====
// per-byte decoder: phase and held hex digit registers, result group for one beat
// depends on qsu_pkg
`default_nettype none

module qsu_decode
  import qsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire in_beat_t   beat,
  input  wire logic [7:0] quote,
  output group_t          grp
);

  phase_t     phase;
  logic [7:0] held_digit;
  dec_t       dec;

  always_comb begin
    dec = decode(phase, held_digit, beat.in_byte, beat.is_last, quote);
    grp = dec.g;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      held_digit <= 8'd0;
    end else if (accept) begin
      phase      <= dec.ph;
      held_digit <= dec.held;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/qsu_serializer.sv =====
// result group register and output sequencer, one result beat per cycle while out_stall is low
// depends on qsu_pkg
`default_nettype none

module qsu_serializer
  import qsu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire group_t    grp_in,
  output logic           can_load,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_data
);

  group_t          grp;
  logic            valid;
  logic [IdxW-1:0] idx;
  logic            is_end;
  logic            finish;

  always_comb begin
    is_end    = ({1'b0, idx} == grp.n - CntW'(1));
    finish    = valid && !out_stall && is_end;
    can_load  = !valid || finish;
    out_valid = valid;
    out_data  = grp.r[idx];
    out_data.run_last = is_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (finish) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (valid && !out_stall) begin
      idx <= idx + IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) grp <= grp_in;
  end

  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    valid |-> grp.n != '0) else $error("empty result group held");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> {1'b0, idx} < grp.n) else $error("result index past group");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (valid && !out_stall && !is_end) |=> valid && idx == $past(idx) + IdxW'(1))
    else $error("result index did not advance");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (finish && !load) |=> !valid) else $error("group not released");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for quoted_string_unescaper: random and directed quoted strings
// against a cycle-free decode predictor; depends on qsu_pkg and the rtl top
`timescale 1ns / 1ps

module tb_top
  import qsu_pkg::*;
();

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam int Busy = 82;
  localparam int Both = 27;
  localparam int LongHold = 80;
  localparam int CycleLimit = 400000;

  class unescape_tracker;
    phase_t     ph;
    logic [7:0] held;
    logic [7:0] quote;
    out_beat_t  decoded_due[$];
    out_beat_t  step_out[$];
    int         errors;

    function new();
      ph = PH_START;
      held = 8'd0;
      quote = QUOTE_RESET;
      errors = 0;
    endfunction

    static function bit hex_digit_ok(logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LF) ||
             (c >= CH_UA && c <= CH_UF);
    endfunction

    function logic [3:0] nibble_of(logic [7:0] c);
      logic [7:0] v;
      if (c >= CH_ZERO && c <= CH_NINE) v = c - CH_ZERO;
      else if (c >= CH_LA && c <= CH_LF) v = c - CH_LA + 8'd10;
      else v = c - CH_UA + 8'd10;
      return v[3:0];
    endfunction

    function void add_result(logic [7:0] b, logic [1:0] k);
      out_beat_t r;
      if (step_out.size() >= MaxRes) return;
      r.out_byte = (k == KIND_DATA) ? b : 8'd0;
      r.kind = k;
      r.run_last = 1'b0;
      step_out.push_back(r);
    endfunction

    // byte seen outside any escape
    function void plain(logic [7:0] b);
      if (ph == PH_START) begin
        ph = PH_TEXT;
        if (b == quote) return;
      end
      if (b == CH_BSLASH) begin
        ph = PH_ESC;
      end else if (b == quote) begin
        add_result(8'd0, KIND_QUOTE);
        ph = PH_START;
      end else begin
        add_result(b, KIND_DATA);
      end
    endfunction

    function void take_byte(in_beat_t d);
      logic [7:0] b;
      logic [7:0] v;
      logic       last;
      b = d.in_byte;
      last = d.is_last;
      step_out.delete();
      case (ph)
        PH_TEXT: plain(b);
        PH_ESC: begin
          if (b == BYTE_NUL) begin
            add_result(8'd0, KIND_END);
            ph = PH_START;
          end else if (b == CH_X) begin
            if (last) begin
              add_result(CH_X, KIND_DATA);
              ph = PH_TEXT;
            end else begin
              ph = PH_X0;
            end
          end else begin
            v = b;
            if (b == CH_N) v = BYTE_LF;
            else if (b == CH_T) v = BYTE_TAB;
            else if (b == CH_R) v = BYTE_CR;
            else if (b == CH_ZERO) v = BYTE_NUL;
            add_result(v, KIND_DATA);
            ph = PH_TEXT;
          end
        end
        PH_X0: begin
          if (hex_digit_ok(b) && !last) begin
            held = b;
            ph = PH_X1;
          end else begin
            add_result(CH_X, KIND_DATA);
            ph = PH_TEXT;
            plain(b);
          end
        end
        PH_X1: begin
          ph = PH_TEXT;
          if (hex_digit_ok(b)) begin
            add_result({nibble_of(held), nibble_of(b)}, KIND_DATA);
          end else begin
            add_result(CH_X, KIND_DATA);
            plain(held);
            plain(b);
          end
        end
        default: begin
          ph = PH_START;
          plain(b);
        end
      endcase
      if (last && ph != PH_START) begin
        add_result(8'd0, KIND_END);
        ph = PH_START;
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
      foreach (step_out[i]) decoded_due.push_back(step_out[i]);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_beat(out_beat_t got);
      out_beat_t want;
      if (decoded_due.size() == 0) begin
        report($sformatf("unexpected beat byte %02h kind %0d", got.out_byte, got.kind));
        return;
      end
      want = decoded_due.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte got %02h want %02h", got.out_byte, want.out_byte));
      if (got.kind !== want.kind)
        report($sformatf("kind got %0d want %0d", got.kind, want.kind));
      if (got.run_last !== want.run_last)
        report($sformatf("run_last got %0b want %0b", got.run_last, want.run_last));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_beat_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_beat_t  out_data;

  unescape_tracker tracker = new();
  int   send_pct = 0;
  int   recv_pct = 0;
  int   sent = 0;
  int   cycles = 0;
  logic hold_on = 1'b0;
  event hold_go;

  quoted_string_unescaper u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // long receiver hold-off
  initial begin
    forever begin
      @(hold_go);
      hold_on = 1'b1;
      repeat (LongHold) @(posedge clk);
      hold_on = 1'b0;
    end
  end

  always @(posedge clk) begin
    out_stall <= hold_on || ($urandom_range(0, 99) < recv_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_beat(out_data);
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    in_beat_t d;
    d.in_byte = b;
    d.is_last = last;
    in_data <= d;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(d);
    sent++;
    if ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_pct);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == tracker.quote || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return CH_ZERO + 8'(v);
    if (v < 16) return CH_LA + 8'(v - 10);
    return CH_UA + 8'(v - 16);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (unescape_tracker::hex_digit_ok(b));
    return b;
  endfunction

  function automatic logic [7:0] escape_letter();
    case ($urandom_range(0, 6))
      0: return CH_N;
      1: return CH_T;
      2: return CH_R;
      3: return CH_ZERO;
      4: return CH_BSLASH;
      5: return CH_SQUOTE;
      default: return CH_DQUOTE;
    endcase
  endfunction

  task automatic send_token();
    case ($urandom_range(0, 9))
      4: begin
        send_beat(CH_BSLASH, 1'b0);
        send_beat(escape_letter(), 1'b0);
      end
      5: begin
        send_beat(CH_BSLASH, 1'b0);
        send_beat(CH_X, 1'b0);
        send_beat(hex_char(), 1'b0);
        send_beat(hex_char(), 1'b0);
      end
      6: begin
        send_beat(CH_BSLASH, 1'b0);
        send_beat(CH_X, 1'b0);
        send_beat(non_hex(), 1'b0);
      end
      7: begin
        send_beat(CH_BSLASH, 1'b0);
        send_beat(CH_X, 1'b0);
        send_beat(hex_char(), 1'b0);
        send_beat(non_hex(), 1'b0);
      end
      8: begin
        send_beat(CH_BSLASH, 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b0);
      end
      default: send_beat(text_byte(), 1'b0);
    endcase
  endtask

  task automatic send_string();
    logic [7:0] q;
    q = tracker.quote;
    if ($urandom_range(0, 9) != 0) send_beat(q, 1'b0);
    repeat ($urandom_range(0, 8)) send_token();
    case ($urandom_range(0, 6))
      0, 1: send_beat(q, 1'b0);
      2: send_beat(q, 1'b1);
      3: send_beat(text_byte(), 1'b1);
      4: begin
        send_beat(CH_BSLASH, 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
      end
      5: begin
        send_beat(CH_BSLASH, 1'b0);
        send_beat(CH_X, 1'b1);
      end
      default: begin
        send_beat(CH_BSLASH, 1'b0);
        send_beat(CH_X, 1'b0);
        send_beat(hex_char(), 1'b1);
      end
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.decoded_due.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] q, input int s_pct, input int r_pct,
                           input int count, input bit hold);
    int stop;
    cfg_wr_data <= q;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.quote = q;
    send_pct = s_pct;
    recv_pct = r_pct;
    if (hold) -> hold_go;
    stop = sent + count;
    while (sent < stop) begin
      if ($urandom_range(0, 9) == 0)
        send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      else
        send_string();
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // escapes, hex escape, extremes, broken hex closing the string, escaped zero
    send_text("\"\\n\\t\\r\\0\\\\\\'\\\"\\xAf");
    send_beat(8'hFF, 1'b0);
    send_text("\\x4\"");
    send_beat(CH_BSLASH, 1'b0);
    send_beat(BYTE_NUL, 1'b0);
    send_beat(QUOTE_RESET, 1'b1);
    send_beat(QUOTE_RESET, 1'b0);
    send_beat(QUOTE_RESET, 1'b1);
    drain();

    run_phase(8'h00, Busy, 0, 32, 1'b0);
    run_phase(8'hFF, 0, Busy, 32, 1'b0);
    run_phase(CH_SQUOTE, Both, Both, 32, 1'b0);
    run_phase(CH_BSLASH, 0, 0, 32, 1'b0);
    run_phase(CH_LOWER_A, Both, Both, 32, 1'b0);
    run_phase(QUOTE_RESET, 0, 0, 32, 1'b1);
    run_phase(QUOTE_RESET, 0, Busy, 32, 1'b0);

    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.decoded_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
